// ===== rtl/core/i2rd_pkg.sv =====
// Package for the integer-to-radix-digits block: shared types, constants,
// the microcode table and the digit-to-ASCII mapping.
// No dependencies.
package i2rd_pkg;

    localparam int CHUNK_BITS = 8;

    localparam logic [5:0] RADIX_MIN   = 6'd2;
    localparam logic [5:0] RADIX_MAX   = 6'd36;
    localparam logic [5:0] RADIX_RESET = 6'd10;

    localparam logic [5:0] DEC_LIMIT = 6'd10;
    localparam logic [6:0] CHAR_ZERO = 7'h30;
    localparam logic [6:0] CHAR_LC_A = 7'h61;
    localparam logic [6:0] CHAR_NINE = 7'h39;
    localparam logic [6:0] CHAR_LC_Z = 7'h7a;

    typedef logic [5:0] digit_t;
    typedef logic [2:0] step_t;

    localparam step_t STEP_IDLE = 3'd0;
    localparam step_t STEP_DIV  = 3'd1;
    localparam step_t STEP_PUSH = 3'd2;
    localparam step_t STEP_READ = 3'd3;
    localparam step_t STEP_EMIT = 3'd4;
    localparam step_t STEP_TEST = 3'd5;
    localparam step_t STEP_BACK = 3'd6;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_IN_IDLE,
        COND_DIV_BUSY,
        COND_Q_NZ,
        COND_OUT_BUSY,
        COND_MORE
    } cond_t;

    typedef struct packed {
        logic accept;
        logic div;
        logic push;
        logic rd;
        logic emit;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic div_last;
        logic q_nz;
        logic out_busy;
        logic more;
    } status_t;

    typedef struct packed {
        ctrl_t ctrl;
        cond_t cond;
        step_t target;
    } uword_t;

    // Microcode: on a true condition go to target, otherwise fall through.
    function automatic uword_t ucode(input step_t step);
        uword_t w;
        w.ctrl   = '0;
        w.cond   = COND_NEXT;
        w.target = STEP_IDLE;
        unique case (step)
            STEP_IDLE:
            begin
                w.ctrl.accept = 1'b1;
                w.cond        = COND_IN_IDLE;
                w.target      = STEP_IDLE;
            end
            STEP_DIV:
            begin
                w.ctrl.div = 1'b1;
                w.cond     = COND_DIV_BUSY;
                w.target   = STEP_DIV;
            end
            STEP_PUSH:
            begin
                w.ctrl.push = 1'b1;
                w.cond      = COND_Q_NZ;
                w.target    = STEP_DIV;
            end
            STEP_READ:
            begin
                w.ctrl.rd = 1'b1;
            end
            STEP_EMIT:
            begin
                w.ctrl.emit = 1'b1;
                w.cond      = COND_OUT_BUSY;
                w.target    = STEP_EMIT;
            end
            STEP_TEST:
            begin
                w.cond   = COND_MORE;
                w.target = STEP_READ;
            end
            default:
            begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic logic [6:0] digit_ascii(input digit_t d);
        logic [6:0] c;
        if (d < DEC_LIMIT)
        begin
            c = CHAR_ZERO + {1'b0, d};
        end
        else
        begin
            c = CHAR_LC_A + {1'b0, d} - {1'b0, DEC_LIMIT};
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/integer_to_radix_digits.sv =====
// Converts one unsigned integer per input transaction into its ASCII digits in a
// radix of 2 to 36 ('0'-'9', then 'a'-'z'), sent most significant first, one
// digit per output transaction, with tlast on the final digit; zero gives a single
// '0'. The radix register resets to 10; values below 2 act as 2 and above 36 as
// 36, and it may be written only while no conversion is in flight. A microcoded
// sequencer steps a small datapath: for each digit it runs one divide pass over
// the value in 8-bit chunks (eight quotient bits per cycle against the radix)
// and then stores the remainder; afterwards each digit is read back, emitted
// and tested in turn. The last digit waits in the output register while the
// next value is already accepted.
// Depends on i2rd_pkg, i2rd_seq and i2rd_dp.
module integer_to_radix_digits
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Radix register write
    input  logic                                radix_we,
    input  logic [5:0]                          radix_wdata,
    // Input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_axis_tdata,   // [VALUE_BITS-1:0] value
    // Output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [7:0]                          m_axis_tdata,   // [6:0] digit_char
    output logic                                m_axis_tlast    // last_digit
);

    i2rd_pkg::ctrl_t   ctrl;
    i2rd_pkg::status_t status;
    logic [6:0]        digit_char;

    // Sequencer: step counter and control store.
    i2rd_seq u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    // Datapath: divider, digit store and output register.
    i2rd_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .status      (status),
        .in_valid    (s_axis_tvalid),
        .in_value    (s_axis_tdata[VALUE_BITS-1:0]),
        .radix_we    (radix_we),
        .radix_wdata (radix_wdata),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_char    (digit_char),
        .out_last    (m_axis_tlast)
    );

    // Take a new value only in the idle step.
    assign s_axis_tready = ctrl.accept;
    assign m_axis_tdata  = {1'b0, digit_char};

    // A shown digit is always a legal character of radix 36 or below.
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            ((m_axis_tdata[6:0] >= i2rd_pkg::CHAR_ZERO &&
              m_axis_tdata[6:0] <= i2rd_pkg::CHAR_NINE) ||
             (m_axis_tdata[6:0] >= i2rd_pkg::CHAR_LC_A &&
              m_axis_tdata[6:0] <= i2rd_pkg::CHAR_LC_Z)))
        else $error("digit outside 0-9 / a-z");

    // After taking a value, go busy dividing.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (!s_axis_tready && ctrl.div))
        else $error("sequencer did not start dividing after accept");

    // An emit step with room in the output register must present a digit.
    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.emit && !status.out_busy) |=> m_axis_tvalid)
        else $error("emit step did not load the output register");

endmodule

// ===== rtl/core/i2rd_seq.sv =====
// Microcode sequencer: step counter, control-word table lookup and
// conditional jumps. Depends on i2rd_pkg.
module i2rd_seq
(
    input  logic             clk,
    input  logic             rst_n,
    input  i2rd_pkg::status_t status,
    output i2rd_pkg::ctrl_t   ctrl
);

    i2rd_pkg::step_t  step_reg;
    i2rd_pkg::step_t  step_next;
    i2rd_pkg::uword_t uword;
    logic             jump;

    assign uword = i2rd_pkg::ucode(step_reg);
    assign ctrl  = uword.ctrl;

    always_comb
    begin
        unique case (uword.cond)
            i2rd_pkg::COND_NEXT:     jump = 1'b0;
            i2rd_pkg::COND_ALWAYS:   jump = 1'b1;
            i2rd_pkg::COND_IN_IDLE:  jump = !status.in_valid;
            i2rd_pkg::COND_DIV_BUSY: jump = !status.div_last;
            i2rd_pkg::COND_Q_NZ:     jump = status.q_nz;
            i2rd_pkg::COND_OUT_BUSY: jump = status.out_busy;
            i2rd_pkg::COND_MORE:     jump = status.more;
            default:                 jump = 1'b0;
        endcase
        step_next = jump ? uword.target : step_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= i2rd_pkg::STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== rtl/core/i2rd_dp.sv =====
// Datapath: radix register, chunked restoring divider, digit memory and
// output register. Driven by control words from i2rd_seq; depends on i2rd_pkg.
module i2rd_dp
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  i2rd_pkg::ctrl_t        ctrl,
    output i2rd_pkg::status_t      status,
    input  logic                   in_valid,
    input  logic [VALUE_BITS-1:0]  in_value,
    input  logic                   radix_we,
    input  logic [5:0]             radix_wdata,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [6:0]             out_char,
    output logic                   out_last
);

    localparam int CB     = i2rd_pkg::CHUNK_BITS;
    localparam int CHUNKS = (VALUE_BITS + i2rd_pkg::CHUNK_BITS - 1) / i2rd_pkg::CHUNK_BITS;
    localparam int DIV_W  = CHUNKS * CB;
    localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int AW     = $clog2(VALUE_BITS);
    localparam int NW     = $clog2(VALUE_BITS + 1);

    logic [5:0]            radix_reg, radix_next;
    logic [DIV_W-1:0]      w_reg, w_next;
    i2rd_pkg::digit_t      rem_reg, rem_next;
    logic [CW-1:0]         chunk_reg, chunk_next;
    logic [NW-1:0]         count_reg, count_next;
    i2rd_pkg::digit_t      rd_data_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [6:0]            out_char_reg, out_char_next;
    logic                  out_last_reg, out_last_next;

    i2rd_pkg::digit_t      digits_mem [VALUE_BITS];

    i2rd_pkg::digit_t      base;
    i2rd_pkg::digit_t      rem_div;
    logic [CB-1:0]         qbits;
    logic [6:0]            trial;
    logic                  chunk_last;
    logic                  load_out;
    logic [NW-1:0]         count_dec;
    logic [AW-1:0]         wr_addr, rd_addr;

    // Clamp the register into 2..36.
    always_comb
    begin
        priority if (radix_reg < i2rd_pkg::RADIX_MIN)
        begin
            base = i2rd_pkg::RADIX_MIN;
        end
        else if (radix_reg > i2rd_pkg::RADIX_MAX)
        begin
            base = i2rd_pkg::RADIX_MAX;
        end
        else
        begin
            base = radix_reg;
        end
    end

    // One chunk of restoring division: one quotient bit per inner step.
    always_comb
    begin
        rem_div = rem_reg;
        trial   = '0;
        qbits   = '0;
        for (int i = 0; i < CB; i++)
        begin
            trial = {rem_div, w_reg[DIV_W-1-i]};
            if (trial >= {1'b0, base})
            begin
                trial           = trial - {1'b0, base};
                qbits[CB-1-i]   = 1'b1;
            end
            rem_div = trial[5:0];
        end
    end

    assign chunk_last = (chunk_reg == CW'(CHUNKS - 1));
    assign count_dec  = count_reg - 1'b1;
    assign wr_addr    = count_reg[AW-1:0];
    assign rd_addr    = count_dec[AW-1:0];

    assign status.in_valid = in_valid;
    assign status.div_last = chunk_last;
    assign status.q_nz     = |w_reg;
    assign status.out_busy = out_valid_reg && !out_ready;
    assign status.more     = (count_reg != '0);

    assign load_out = ctrl.emit && !status.out_busy;

    always_comb
    begin
        radix_next     = radix_we ? radix_wdata : radix_reg;
        w_next         = w_reg;
        rem_next       = rem_reg;
        chunk_next     = chunk_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;

        if (ctrl.accept && in_valid)
        begin
            w_next     = DIV_W'(in_value);
            rem_next   = '0;
            chunk_next = '0;
            count_next = '0;
        end
        if (ctrl.div)
        begin
            w_next     = (w_reg << CB) | DIV_W'(qbits);
            rem_next   = rem_div;
            chunk_next = chunk_last ? '0 : chunk_reg + 1'b1;
        end
        if (ctrl.push)
        begin
            rem_next   = '0;
            count_next = count_reg + 1'b1;
        end
        if (ctrl.rd)
        begin
            count_next = count_dec;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_char_next  = i2rd_pkg::digit_ascii(rd_data_reg);
            out_last_next  = (count_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg     <= i2rd_pkg::RADIX_RESET;
            chunk_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            radix_reg     <= radix_next;
            chunk_reg     <= chunk_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg        <= w_next;
        rem_reg      <= rem_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    // Digit store: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            digits_mem[wr_addr] <= rem_reg;
        end
        if (ctrl.rd)
        begin
            rd_data_reg <= digits_mem[rd_addr];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

endmodule
